// ===== rtl/usbhps_pkg.sv =====
// Shared types, codes and constants of the hub port status engine.
// No dependencies; the top, front end, queue and back end import this package.
`timescale 1ns / 1ps

package usbhps_pkg;

	localparam int PORT_COUNT_DEF = 4;
	localparam int PORT_W        = 3;
	localparam int QDEPTH        = 2;
	localparam int IDX_W         = 4;

	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_CONNECT = 2'd1;
	localparam logic [1:0] OP_POLL    = 2'd2;

	localparam logic [1:0] OUT_OK    = 2'd0;
	localparam logic [1:0] OUT_STALL = 2'd1;
	localparam logic [1:0] OUT_NAK   = 2'd2;

	localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;

	localparam logic [4:0] RECIP_PORT = 5'd3;

	localparam logic [15:0] FSEL_ENABLE  = 16'd1;
	localparam logic [15:0] FSEL_RESET   = 16'd4;
	localparam logic [15:0] FSEL_POWER   = 16'd8;
	localparam logic [15:0] FSEL_C_CONN  = 16'd16;
	localparam logic [15:0] FSEL_C_RESET = 16'd20;

	// wPortStatus / wPortChange bit positions
	localparam int ST_CONN_B = 0;
	localparam int ST_EN_B   = 1;
	localparam int ST_RST_B  = 4;
	localparam int ST_PWR_B  = 8;
	localparam int ST_HS_B   = 10;
	localparam int CH_CONN_B = 0;
	localparam int CH_RST_B  = 4;

	localparam logic [7:0] HUB_DESC_TYPE  = 8'h29;
	localparam logic [7:0] HUB_CHARS_LO   = 8'h04;
	localparam logic [7:0] PWR_ON_TO_GOOD = 8'd50;

	localparam logic [IDX_W-1:0] DESC_LAST   = 4'd8;
	localparam logic [IDX_W-1:0] STATUS_LAST = 4'd3;

	typedef enum logic [2:0] {
		CMD_DESC,
		CMD_STATUS,
		CMD_SET,
		CMD_CLEAR,
		CMD_CONNECT,
		CMD_POLL,
		CMD_STALL
	} cmd_kind_t;

	typedef enum logic [2:0] {
		SEL_ENABLE,
		SEL_RESET,
		SEL_POWER,
		SEL_C_CONN,
		SEL_C_RESET,
		SEL_OTHER
	} sel_t;

	// flag: device attached for a connect event, zero length for a poll
	typedef struct packed {
		cmd_kind_t          kind;
		logic [PORT_W-1:0]  port;
		sel_t               sel;
		logic               flag;
	} cmd_t;

	function automatic logic [7:0] desc_byte(input logic [IDX_W-1:0] idx,
			input logic [7:0] nports, input logic [7:0] blen);
		logic [7:0] b;
		case (idx)
			4'd0: b = blen;
			4'd1: b = HUB_DESC_TYPE;
			4'd2: b = nports;
			4'd3: b = HUB_CHARS_LO;
			4'd5: b = PWR_ON_TO_GOOD;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/usbhps_if.sv =====
// Valid/ready channel interfaces of the hub port status engine.
// Request channel carries one item; response channel carries one result.
`timescale 1ns / 1ps

interface usbhps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] feature_value;
	logic [15:0] request_index;
	logic [2:0]  event_port;
	logic        port_connected;
	logic [9:0]  poll_max_length;

	modport source(output valid, operation, request_type, request_code, feature_value,
		request_index, event_port, port_connected, poll_max_length, input ready);
	modport sink(input valid, operation, request_type, request_code, feature_value,
		request_index, event_port, port_connected, poll_max_length, output ready);
endinterface

interface usbhps_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] outcome;
	logic       data_valid;
	logic [7:0] data_byte;
	logic       last;

	modport source(output valid, outcome, data_valid, data_byte, last, input ready);
	modport sink(input valid, outcome, data_valid, data_byte, last, output ready);
endinterface

// ===== rtl/usb_hub_port_status_engine_top.sv =====
// Top level of the hub port status engine: front end, command queue, back end.
// Depends on usbhps_pkg, usbhps_if, usbhps_front, usbhps_fifo and usbhps_back.
`timescale 1ns / 1ps

// Usage
//   in_ch  : one transaction per item (class request, connect event or poll).
//   out_ch : one transaction per result; last marks the final result of an item.
//   The front end decodes an item in the cycle it is accepted and pushes a
//   command into a two-entry queue. The back end pops one command at a time,
//   applies its update to the port status/change words on the pop, then
//   emits one result per cycle into the output register while that register is free.
// Flow
//   An accepted item passes the queue and the back end's command register before
//   its first result is registered in the output register. An item holds the
//   back end from its idle state through its results: GET_STATUS gives four,
//   GET_DESCRIPTOR nine, every other item one. The back end takes a new command
//   only in its idle state; the queue lets the next items be accepted while it works.
// Reset
//   arst_n clears all port status and change words, empties the queue and
//   drops out_ch.valid.
// Backpressure
//   While out_ch.ready is low the output register holds its result and the
//   back end waits; once the queue fills, in_ch.ready drops.

module usb_hub_port_status_engine_top #(
	parameter int PORT_COUNT = usbhps_pkg::PORT_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	usbhps_in_if.sink     in_ch,
	usbhps_out_if.source  out_ch
);
	import usbhps_pkg::*;

	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic push;
	logic pop;
	logic full;
	logic empty;

	// Decode incoming transactions into commands
	usbhps_front #(
		.PORT_COUNT(PORT_COUNT)
	) u_front (
		.in_ch   (in_ch),
		.full    (full),
		.push    (push),
		.push_cmd(push_cmd)
	);

	// Decouple decode from execution
	usbhps_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.pop_cmd (pop_cmd),
		.empty   (empty)
	);

	// Execute commands and stream results
	usbhps_back #(
		.PORT_COUNT(PORT_COUNT)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.empty (empty),
		.pop   (pop),
		.cmd   (pop_cmd),
		.out_ch(out_ch)
	);

	// A NAK never carries data and always closes the item
	a_nak_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.outcome == OUT_NAK) |-> (!out_ch.data_valid && out_ch.last))
		else $error("NAK result with data or without last");

	// Data bytes only ride on accepted results
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data_valid) |-> (out_ch.outcome == OUT_OK))
		else $error("data byte on a stalled or NAK result");

	// A result without data is a single result with a zero byte
	a_nodata_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.data_valid) |-> (out_ch.last && out_ch.data_byte == 8'h00))
		else $error("dataless result not single or byte not zero");

endmodule

// ===== rtl/usbhps_front.sv =====
// Front end: accept request transactions and decode them into commands.
// Depends on usbhps_pkg and usbhps_in_if.
`timescale 1ns / 1ps

module usbhps_front #(
	parameter int PORT_COUNT = usbhps_pkg::PORT_COUNT_DEF
) (
	usbhps_in_if.sink          in_ch,
	input  logic               full,
	output logic               push,
	output usbhps_pkg::cmd_t   push_cmd
);
	import usbhps_pkg::*;

	localparam logic [15:0] NP_IDX  = 16'(PORT_COUNT);
	localparam logic [PORT_W:0] NP_EV = (PORT_W + 1)'(PORT_COUNT);

	logic [15:0] widx_m1;
	logic        port_ok;

	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;

	assign widx_m1 = in_ch.request_index - 16'd1;
	assign port_ok = (in_ch.request_index != 16'd0) && (in_ch.request_index <= NP_IDX);

	always_comb begin
		push_cmd.kind = CMD_STALL;
		push_cmd.port = '0;
		push_cmd.flag = 1'b0;

		case (in_ch.feature_value)
			FSEL_ENABLE:  push_cmd.sel = SEL_ENABLE;
			FSEL_RESET:   push_cmd.sel = SEL_RESET;
			FSEL_POWER:   push_cmd.sel = SEL_POWER;
			FSEL_C_CONN:  push_cmd.sel = SEL_C_CONN;
			FSEL_C_RESET: push_cmd.sel = SEL_C_RESET;
			default:      push_cmd.sel = SEL_OTHER;
		endcase

		case (in_ch.operation)
			OP_REQUEST: begin
				if (in_ch.request_code == REQ_GET_DESCRIPTOR) begin
					push_cmd.kind = CMD_DESC;
				end else if (in_ch.request_type[4:0] == RECIP_PORT && port_ok) begin
					push_cmd.port = widx_m1[PORT_W-1:0];
					case (in_ch.request_code)
						REQ_GET_STATUS:    push_cmd.kind = CMD_STATUS;
						REQ_CLEAR_FEATURE: push_cmd.kind = CMD_CLEAR;
						REQ_SET_FEATURE:   push_cmd.kind = CMD_SET;
						default:           push_cmd.kind = CMD_STALL;
					endcase
				end
			end
			OP_CONNECT: begin
				if ({1'b0, in_ch.event_port} < NP_EV) begin
					push_cmd.kind = CMD_CONNECT;
					push_cmd.port = in_ch.event_port;
					push_cmd.flag = in_ch.port_connected;
				end
			end
			OP_POLL: begin
				push_cmd.kind = CMD_POLL;
				push_cmd.flag = (in_ch.poll_max_length == 10'd0);
			end
			default: push_cmd.kind = CMD_STALL;
		endcase
	end

endmodule

// ===== rtl/usbhps_fifo.sv =====
// Short command queue between front end and back end.
// Depends on usbhps_pkg.
`timescale 1ns / 1ps

module usbhps_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  usbhps_pkg::cmd_t   push_cmd,
	output logic               full,
	input  logic               pop,
	output usbhps_pkg::cmd_t   pop_cmd,
	output logic               empty
);
	import usbhps_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

	cmd_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/usbhps_back.sv =====
// Back end: hold per-port status/change words, apply commands, stream results.
// Depends on usbhps_pkg and usbhps_out_if.
`timescale 1ns / 1ps

module usbhps_back #(
	parameter int PORT_COUNT = usbhps_pkg::PORT_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	output logic               pop,
	input  usbhps_pkg::cmd_t   cmd,
	usbhps_out_if.source       out_ch
);
	import usbhps_pkg::*;

	localparam int PIDX_W   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int BM_BYTES = (PORT_COUNT + 8) / 8;
	localparam logic [7:0] DESC_LEN_B = 8'(7 + 2 * BM_BYTES);
	localparam logic [7:0] NPORTS_B   = 8'(PORT_COUNT);

	typedef enum logic {ST_IDLE, ST_EMIT} state_t;

	state_t           state_q;
	cmd_t             cur_q;
	logic [IDX_W-1:0] idx_q;
	logic             ovalid_q;
	logic [1:0]       outcome_q;
	logic             dvalid_q;
	logic [7:0]       dbyte_q;
	logic             last_q;

	logic [15:0] status_q [PORT_COUNT];
	logic [15:0] change_q [PORT_COUNT];

	logic [7:0]  bitmap;
	logic [15:0] cur_status;
	logic [15:0] cur_change;
	logic        slot_free;
	logic [1:0]  r_outcome;
	logic        r_valid;
	logic [7:0]  r_byte;
	logic        r_last;

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign slot_free = !ovalid_q || out_ch.ready;

	// Apply state updates as the command leaves the queue
	for (genvar i = 0; i < PORT_COUNT; i++) begin : g_port
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				status_q[i] <= '0;
				change_q[i] <= '0;
			end else if (pop && cmd.port == PORT_W'(i)) begin
				case (cmd.kind)
					CMD_SET: begin
						if (cmd.sel == SEL_POWER) begin
							status_q[i][ST_PWR_B] <= 1'b1;
						end else if (cmd.sel == SEL_RESET) begin
							status_q[i][ST_EN_B]  <= 1'b1;
							status_q[i][ST_HS_B]  <= 1'b1;
							status_q[i][ST_RST_B] <= 1'b0;
							change_q[i][CH_RST_B] <= 1'b1;
						end
					end
					CMD_CLEAR: begin
						case (cmd.sel)
							SEL_POWER:   status_q[i][ST_PWR_B]  <= 1'b0;
							SEL_ENABLE:  status_q[i][ST_EN_B]   <= 1'b0;
							SEL_C_CONN:  change_q[i][CH_CONN_B] <= 1'b0;
							SEL_C_RESET: change_q[i][CH_RST_B]  <= 1'b0;
							default: ;
						endcase
					end
					CMD_CONNECT: begin
						status_q[i][ST_CONN_B] <= cmd.flag;
						if (!cmd.flag) begin
							status_q[i][ST_EN_B] <= 1'b0;
						end
						change_q[i][CH_CONN_B] <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		bitmap = '0;
		for (int i = 0; i < PORT_COUNT; i++) begin
			bitmap[i + 1] = |change_q[i];
		end
	end

	assign cur_status = status_q[cur_q.port[PIDX_W-1:0]];
	assign cur_change = change_q[cur_q.port[PIDX_W-1:0]];

	always_comb begin
		r_outcome = OUT_OK;
		r_valid   = 1'b0;
		r_byte    = 8'h00;
		r_last    = 1'b1;
		case (cur_q.kind)
			CMD_DESC: begin
				r_valid = 1'b1;
				r_byte  = desc_byte(idx_q, NPORTS_B, DESC_LEN_B);
				r_last  = (idx_q == DESC_LAST);
			end
			CMD_STATUS: begin
				r_valid = 1'b1;
				case (idx_q[1:0])
					2'd0:    r_byte = cur_status[7:0];
					2'd1:    r_byte = cur_status[15:8];
					2'd2:    r_byte = cur_change[7:0];
					default: r_byte = cur_change[15:8];
				endcase
				r_last = (idx_q == STATUS_LAST);
			end
			CMD_POLL: begin
				if (bitmap == 8'h00) begin
					r_outcome = OUT_NAK;
				end else if (!cur_q.flag) begin
					r_valid = 1'b1;
					r_byte  = bitmap;
				end
			end
			CMD_STALL: r_outcome = OUT_STALL;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= '0;
			idx_q     <= '0;
			ovalid_q  <= 1'b0;
			outcome_q <= OUT_OK;
			dvalid_q  <= 1'b0;
			dbyte_q   <= '0;
			last_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ovalid_q && out_ch.ready) begin
						ovalid_q <= 1'b0;
					end
					if (!empty) begin
						cur_q   <= cmd;
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						ovalid_q  <= 1'b1;
						outcome_q <= r_outcome;
						dvalid_q  <= r_valid;
						dbyte_q   <= r_byte;
						last_q    <= r_last;
						if (r_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid      = ovalid_q;
	assign out_ch.outcome    = outcome_q;
	assign out_ch.data_valid = dvalid_q;
	assign out_ch.data_byte  = dbyte_q;
	assign out_ch.last       = last_q;

endmodule
